// ----- rtl/sid_pkg.sv -----
// sid_pkg: shared types, constants and helpers of the string interner.
// Used by sid_front, sid_queue, sid_back and string_interner_dedup.
package sid_pkg;

	localparam logic [31:0] HASH_INIT  = 32'h811c9dc5;
	localparam logic [31:0] HASH_PRIME = 32'h01000193;
	localparam int          LEN_W      = 11;
	localparam int          CNT_W      = 12;
	localparam int          ID_W       = 16;
	localparam int          LOAD_NUM   = 10;
	localparam int          LOAD_DEN   = 7;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_LOADLIM = 2'd1,
		ST_FULL    = 2'd2,
		ST_TOOLONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		JOB_EMPTY,
		JOB_LONG,
		JOB_LOOKUP
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [31:0]        hash;
		logic [LEN_W-1:0]   len;
	} job_t;

	typedef struct packed {
		logic               en;
		logic [LEN_W-1:0]   addr;
		logic [7:0]         data;
	} stage_wr_t;

	typedef struct packed {
		logic clearing;
		logic lookup_done;
	} back_stat_t;

	typedef enum logic [3:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SLOT_RD,
		BK_SLOT_CHK,
		BK_CMP,
		BK_NEXT,
		BK_MISS,
		BK_WR,
		BK_INS,
		BK_RESP
	} back_state_t;

	// byte k of a stored block [len:4][bytes][zero]
	function automatic logic [7:0] block_byte(input logic [CNT_W-1:0] k,
			input logic [LEN_W-1:0] len, input logic [7:0] stg);
		logic [7:0] b;
		if (k < CNT_W'(4)) begin
			unique case (k[1:0])
				2'd0: b = len[7:0];
				2'd1: b = {5'b0, len[10:8]};
				default: b = 8'h00;
			endcase
		end else if (k == CNT_W'(len) + CNT_W'(4)) begin
			b = 8'h00;
		end else begin
			b = stg;
		end
		return b;
	endfunction

endpackage

// ----- rtl/sid_front.sv -----
// sid_front: accepts bytes, keeps the FNV-1a hash and staging length,
// and pushes one job per string end. Depends on sid_pkg.
module sid_front #(
	parameter int MAX_STRING_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [7:0]          byte_value,
	input  logic                last_byte,
	input  logic                empty_string,
	input  logic                q_full,
	output logic                q_push,
	output sid_pkg::job_t       q_job,
	output sid_pkg::stage_wr_t  stage_wr,
	input  sid_pkg::back_stat_t bstat
);
	localparam int LW = $clog2(MAX_STRING_LEN + 1);

	logic [31:0]   hash_q;
	logic [31:0]   hash_nx;
	logic [LW-1:0] len_q;
	logic [LW-1:0] len_nx;
	logic          long_q;
	logic          long_nx;
	logic          pend_q;
	logic          acc;

	assign req_stall = bstat.clearing || q_full || pend_q;
	assign acc       = req_valid && !req_stall;

	always_comb begin
		hash_nx = (hash_q ^ 32'(byte_value)) * sid_pkg::HASH_PRIME;
		len_nx  = len_q;
		long_nx = long_q;
		stage_wr.en   = 1'b0;
		stage_wr.addr = sid_pkg::LEN_W'(len_q);
		stage_wr.data = byte_value;
		if (len_q < LW'(MAX_STRING_LEN)) begin
			len_nx = len_q + LW'(1);
			stage_wr.en = acc && !empty_string;
		end else begin
			long_nx = 1'b1;
		end
		q_push   = acc && (empty_string || last_byte);
		q_job.hash = hash_nx;
		q_job.len  = sid_pkg::LEN_W'(len_nx);
		if (empty_string) begin
			q_job.kind = sid_pkg::JOB_EMPTY;
		end else if (long_nx) begin
			q_job.kind = sid_pkg::JOB_LONG;
		end else begin
			q_job.kind = sid_pkg::JOB_LOOKUP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sid_pkg::HASH_INIT;
			len_q  <= '0;
			long_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (bstat.lookup_done) begin
				pend_q <= 1'b0;
			end
			if (acc) begin
				if (empty_string || last_byte) begin
					hash_q <= sid_pkg::HASH_INIT;
					len_q  <= '0;
					long_q <= 1'b0;
					if (q_job.kind == sid_pkg::JOB_LOOKUP) begin
						pend_q <= 1'b1;
					end
				end else begin
					hash_q <= hash_nx;
					len_q  <= len_nx;
					long_q <= long_nx;
				end
			end
		end
	end
endmodule

// ----- rtl/sid_queue.sv -----
// sid_queue: two-entry job queue between front and back.
// Depends on sid_pkg.
module sid_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sid_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output sid_pkg::job_t dout,
	output logic          empty
);
	sid_pkg::job_t ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

// ----- rtl/sid_back.sv -----
// sid_back: slot table probe, stored-byte compare, block append and
// result register. Holds the staging, slot and byte memories. Depends on sid_pkg.
module sid_back #(
	parameter int TABLE_SLOTS    = 1024,
	parameter int STORE_BYTES    = 65536,
	parameter int MAX_STRING_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sid_pkg::job_t       q_job,
	input  logic                q_empty,
	output logic                q_pop,
	input  sid_pkg::stage_wr_t  stage_wr,
	output sid_pkg::back_stat_t bstat,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [15:0]         string_id,
	output logic                newly_added,
	output logic [1:0]          status
);
	localparam int TW   = $clog2(TABLE_SLOTS);
	localparam int AW   = $clog2(STORE_BYTES);
	localparam int FW   = AW + 1;
	localparam int UW   = TW + 1;
	localparam int SW   = (MAX_STRING_LEN > 1) ? $clog2(MAX_STRING_LEN) : 1;
	localparam int SD   = 2 ** SW;
	localparam int LW   = sid_pkg::LEN_W;
	localparam int CW   = sid_pkg::CNT_W;
	localparam int IW   = sid_pkg::ID_W;
	localparam int LOAD_LIM = TABLE_SLOTS * sid_pkg::LOAD_DEN;

	logic [7:0]      stage_mem [SD];
	logic [IW:0]     slot_mem  [TABLE_SLOTS];
	logic [7:0]      store_mem [STORE_BYTES];

	sid_pkg::back_state_t state_q, state_d;
	sid_pkg::job_kind_t   kind_q;

	logic [TW-1:0]   clr_q;
	logic [TW-1:0]   idx_q;
	logic [TW:0]     probe_q;
	logic [IW:0]     slot_rd_q;
	logic [LW-1:0]   len_q;
	logic [IW-1:0]   id_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   chk_s1;
	logic            chk_v_s1;
	logic [7:0]      store_rd_q;
	logic [7:0]      stage_rd_q;
	logic [FW-1:0]   fill_q;
	logic [UW-1:0]   used_q;

	logic [IW-1:0]   res_id_q, res_id_d;
	logic            res_add_q, res_add_d;
	sid_pkg::status_t res_st_q, res_st_d;
	logic            res_set;

	logic            out_v_q;
	logic [IW-1:0]   out_id_q;
	logic            out_add_q;
	logic [1:0]      out_st_q;
	logic            out_free;
	logic            resp_go;

	logic [CW-1:0]   last_cmp;
	logic [CW-1:0]   last_wr;
	logic [7:0]      exp_b;
	logic            cmp_bad;
	logic            load_fail;
	logic            store_fail;
	logic [AW-1:0]   store_raddr;
	logic [AW-1:0]   store_waddr;
	logic [SW-1:0]   stage_raddr;
	logic [CW-1:0]   k_m4;

	assign out_free    = !out_v_q || !rsp_stall;
	assign last_cmp    = CW'(len_q) + CW'(3);
	assign last_wr     = CW'(len_q) + CW'(4);
	assign exp_b       = sid_pkg::block_byte(chk_s1, len_q, stage_rd_q);
	assign cmp_bad     = chk_v_s1 && (store_rd_q != exp_b);
	assign load_fail   = (32'(used_q) + 32'd1) * 32'(sid_pkg::LOAD_NUM) > 32'(LOAD_LIM);
	assign store_fail  = (32'(fill_q) + 32'(len_q) + 32'd5 > 32'(STORE_BYTES))
		|| (32'(fill_q) > 32'hFFFF);
	assign store_raddr = AW'(32'(id_q) + 32'(k_q));
	assign store_waddr = AW'(32'(fill_q) + 32'(chk_s1));
	assign k_m4        = k_q - CW'(4);
	assign stage_raddr = k_m4[SW-1:0];

	assign rsp_valid   = out_v_q;
	assign string_id   = out_id_q;
	assign newly_added = out_add_q;
	assign status      = out_st_q;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		res_set  = 1'b0;
		res_id_d = '0;
		res_add_d = 1'b0;
		res_st_d = sid_pkg::ST_OK;
		resp_go  = 1'b0;
		bstat.clearing    = (state_q == sid_pkg::BK_CLEAR);
		bstat.lookup_done = 1'b0;
		unique case (state_q)
			sid_pkg::BK_CLEAR: begin
				if (clr_q == {TW{1'b1}}) begin
					state_d = sid_pkg::BK_IDLE;
				end
			end
			sid_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (q_job.kind)
						sid_pkg::JOB_EMPTY: begin
							res_set = 1'b1;
							state_d = sid_pkg::BK_RESP;
						end
						sid_pkg::JOB_LONG: begin
							res_set  = 1'b1;
							res_st_d = sid_pkg::ST_TOOLONG;
							state_d  = sid_pkg::BK_RESP;
						end
						default: state_d = sid_pkg::BK_SLOT_RD;
					endcase
				end
			end
			sid_pkg::BK_SLOT_RD: state_d = sid_pkg::BK_SLOT_CHK;
			sid_pkg::BK_SLOT_CHK: begin
				state_d = slot_rd_q[IW] ? sid_pkg::BK_CMP : sid_pkg::BK_MISS;
			end
			sid_pkg::BK_CMP: begin
				if (cmp_bad) begin
					state_d = sid_pkg::BK_NEXT;
				end else if (chk_v_s1 && chk_s1 == last_cmp) begin
					res_set  = 1'b1;
					res_id_d = id_q;
					state_d  = sid_pkg::BK_RESP;
				end
			end
			sid_pkg::BK_NEXT: begin
				if (probe_q == (TW+1)'(TABLE_SLOTS - 1)) begin
					res_set  = 1'b1;
					res_st_d = sid_pkg::ST_LOADLIM;
					state_d  = sid_pkg::BK_RESP;
				end else begin
					state_d = sid_pkg::BK_SLOT_RD;
				end
			end
			sid_pkg::BK_MISS: begin
				if (load_fail) begin
					res_set  = 1'b1;
					res_st_d = sid_pkg::ST_LOADLIM;
					state_d  = sid_pkg::BK_RESP;
				end else if (store_fail) begin
					res_set  = 1'b1;
					res_st_d = sid_pkg::ST_FULL;
					state_d  = sid_pkg::BK_RESP;
				end else begin
					state_d = sid_pkg::BK_WR;
				end
			end
			sid_pkg::BK_WR: begin
				if (chk_v_s1 && chk_s1 == last_wr) begin
					state_d = sid_pkg::BK_INS;
				end
			end
			sid_pkg::BK_INS: begin
				res_set   = 1'b1;
				res_id_d  = IW'(fill_q);
				res_add_d = 1'b1;
				state_d   = sid_pkg::BK_RESP;
			end
			sid_pkg::BK_RESP: begin
				if (out_free) begin
					resp_go = 1'b1;
					bstat.lookup_done = (kind_q == sid_pkg::JOB_LOOKUP);
					state_d = sid_pkg::BK_IDLE;
				end
			end
			default: state_d = sid_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stage_wr.en) begin
			stage_mem[stage_wr.addr[SW-1:0]] <= stage_wr.data;
		end
		stage_rd_q <= stage_mem[stage_raddr];
		if (state_q == sid_pkg::BK_WR && chk_v_s1) begin
			store_mem[store_waddr] <= exp_b;
		end
		store_rd_q <= store_mem[store_raddr];
		if (state_q == sid_pkg::BK_CLEAR) begin
			slot_mem[clr_q] <= '0;
		end else if (state_q == sid_pkg::BK_INS) begin
			slot_mem[idx_q] <= {1'b1, IW'(fill_q)};
		end
		slot_rd_q <= slot_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			len_q <= q_job.len;
			idx_q <= q_job.hash[TW-1:0];
		end else if (state_q == sid_pkg::BK_NEXT) begin
			idx_q <= idx_q + TW'(1);
		end
		if (state_q == sid_pkg::BK_SLOT_CHK) begin
			id_q <= slot_rd_q[IW-1:0];
		end
		if (res_set) begin
			res_id_q  <= res_id_d;
			res_add_q <= res_add_d;
			res_st_q  <= res_st_d;
		end
		if (resp_go) begin
			out_id_q  <= res_id_q;
			out_add_q <= res_add_q;
			out_st_q  <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sid_pkg::BK_CLEAR;
			kind_q   <= sid_pkg::JOB_EMPTY;
			clr_q    <= '0;
			probe_q  <= '0;
			k_q      <= '0;
			chk_s1   <= '0;
			chk_v_s1 <= 1'b0;
			fill_q   <= FW'(5);
			used_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sid_pkg::BK_CLEAR) begin
				clr_q <= clr_q + TW'(1);
			end
			if (q_pop) begin
				kind_q  <= q_job.kind;
				probe_q <= '0;
			end else if (state_q == sid_pkg::BK_NEXT) begin
				probe_q <= probe_q + (TW+1)'(1);
			end
			if (state_q == sid_pkg::BK_CMP || state_q == sid_pkg::BK_WR) begin
				if (k_q <= ((state_q == sid_pkg::BK_CMP) ? last_cmp : last_wr)) begin
					chk_s1   <= k_q;
					chk_v_s1 <= 1'b1;
					k_q      <= k_q + CW'(1);
				end else begin
					chk_v_s1 <= 1'b0;
				end
			end else begin
				k_q      <= '0;
				chk_v_s1 <= 1'b0;
			end
			if (state_q == sid_pkg::BK_INS) begin
				fill_q <= fill_q + FW'(len_q) + FW'(5);
				used_q <= used_q + UW'(1);
			end
			if (resp_go) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/string_interner_dedup.sv -----
// string_interner_dedup: top level; front, job queue and back.
// Depends on sid_pkg, sid_front, sid_queue and sid_back.
//
// Strings arrive one byte per request, taken at one byte per cycle while
// req_stall is low as the bytes of a string are hashed and staged. At a
// string end the back probes the slot table: it reads and checks each slot
// visited, steps past a slot whose block differs, compares the bytes of every
// candidate, appends a new block on a miss when there is room, then posts the
// result; the result register and one slot of the job queue set the rate of
// empty and too-long strings. Bytes of the next string are held off until the
// current lookup is done, since they share the staging memory. After reset the
// slot table is swept, one slot a cycle, and no request is taken until the
// sweep is done.
module string_interner_dedup #(
	parameter int TABLE_SLOTS    = 1024,
	parameter int STORE_BYTES    = 65536,
	parameter int MAX_STRING_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	input  logic        empty_string,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] string_id,
	output logic        newly_added,
	output logic [1:0]  status
);
	logic                q_full;
	logic                q_empty;
	logic                q_push;
	logic                q_pop;
	sid_pkg::job_t       job_in;
	sid_pkg::job_t       job_out;
	sid_pkg::stage_wr_t  stage_wr;
	sid_pkg::back_stat_t bstat;

	sid_front #(
		.MAX_STRING_LEN(MAX_STRING_LEN)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.byte_value(byte_value), .last_byte(last_byte),
		.empty_string(empty_string),
		.q_full(q_full), .q_push(q_push), .q_job(job_in),
		.stage_wr(stage_wr), .bstat(bstat)
	);

	sid_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .din(job_in), .full(q_full),
		.pop(q_pop), .dout(job_out), .empty(q_empty)
	);

	sid_back #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.STORE_BYTES(STORE_BYTES),
		.MAX_STRING_LEN(MAX_STRING_LEN)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_job(job_out), .q_empty(q_empty), .q_pop(q_pop),
		.stage_wr(stage_wr), .bstat(bstat),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.string_id(string_id), .newly_added(newly_added), .status(status)
	);
endmodule
